// File: hw/rtl/madap_pkg.sv
// Shared types and constants of the multichannel ADC averager and packetiser.
`timescale 1ns / 1ps

package madap_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CMD_W      = 16;
  localparam int unsigned LAG_W      = 3;
  localparam int unsigned AVG_CH_W   = 3;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned DAC_W      = 24;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_ADDR_W = 1;

  // Command word layout: channel field starts at bit 9
  localparam int unsigned CMD_SHIFT = 9;

  // Register reset values
  localparam logic [CMD_W-1:0] CMD_BASE_RST = 16'hA100;
  localparam logic [LAG_W-1:0] LAG_RST      = 3'd7;

  // Two's complement to offset binary
  localparam logic [SAMPLE_W-1:0] SAMPLE_FLIP = 16'h8000;

  // DAC word: bits 19 and 20 always set, DAC channel in bit 16
  localparam logic [DAC_W-1:0] DAC_FIXED  = 24'h18_0000;
  localparam int unsigned      DAC_CH_BIT = 16;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_COMMAND_BASE = 1'b0,
    CFG_CHANNEL_LAG  = 1'b1
  } cfg_reg_e;

  // One result item
  typedef struct packed {
    logic [CMD_W-1:0]    adc_command;
    logic                avg_valid;
    logic [SAMPLE_W-1:0] avg_value;
    logic [AVG_CH_W-1:0] avg_channel;
    logic [SLOT_W-1:0]   packet_slot;
    logic                packet_bank;
    logic                packet_done;
    logic                dac_valid;
    logic [DAC_W-1:0]    dac_word;
  } result_t;

endpackage

// File: hw/rtl/multichannel_adc_average_packetizer_unit.sv
// Top level: ADC command, boxcar averaging, packet slotting and DAC word generation.
`timescale 1ns / 1ps

// Usage
// Every request on the input channel (in_valid_i / in_ready_o) is one ADC
// frame: the received-sample flag, the signed sample and the DAC room flag.
// Every frame yields exactly one result on the output channel (out_valid_o /
// out_ready_i): the ADC command word, an optional averaged word with its
// packet slot and bank, and an optional 24-bit DAC word.
// Results are registered: a frame taken at one edge has its result valid after
// that edge. Throughput is one frame per cycle without stalls; the whole frame
// is worked out in a single pass from the line taps into the result register.
// The sample store is a shift line of NUM_CHANNELS * AVG_DEPTH entries; the
// averaging taps sit at fixed distances of one channel sweep.
// Reset clears the store, the counters and the result valid flag, and loads
// the command base and channel lag registers with their defaults; frames are
// taken from the first cycle after reset.
// When the receiver stalls, the result is held and one more frame is taken
// only when the output register is empty or is being emptied in that cycle.
// Configuration writes (cfg_we_i) take effect at the next edge and belong
// only to periods with no frame in flight.
module multichannel_adc_average_packetizer_unit #(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned AVG_DEPTH    = 4,
  parameter int unsigned PACKET_WORDS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [madap_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [madap_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // frame requests
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 rx_valid_i,
  input  logic signed [madap_pkg::SAMPLE_W-1:0] rx_sample_i,
  input  logic                                 dac_room_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [madap_pkg::CMD_W-1:0]          adc_command_o,
  output logic                                 avg_valid_o,
  output logic [madap_pkg::SAMPLE_W-1:0]       avg_value_o,
  output logic [madap_pkg::AVG_CH_W-1:0]       avg_channel_o,
  output logic [madap_pkg::SLOT_W-1:0]         packet_slot_o,
  output logic                                 packet_bank_o,
  output logic                                 packet_done_o,
  output logic                                 dac_valid_o,
  output logic [madap_pkg::DAC_W-1:0]          dac_word_o
);

  localparam int unsigned SW        = madap_pkg::SAMPLE_W;
  localparam int unsigned CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned RD_W      = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned SLOT_CW   = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;
  localparam int unsigned TOTAL     = NUM_CHANNELS * AVG_DEPTH;
  localparam int unsigned TAP_W     = $clog2(TOTAL);
  localparam int unsigned LAG_STEPS = (NUM_CHANNELS + 6) / NUM_CHANNELS;
  localparam int unsigned LAGSUM_W  = CH_W + 2;
  // average: floor(sum / AVG_DEPTH) via a rounded-up reciprocal
  localparam int unsigned SUM_W     = SW + $clog2(AVG_DEPTH);
  localparam int unsigned DIV_SH    = SUM_W + $clog2(AVG_DEPTH);
  localparam int unsigned RECIP_W   = SUM_W + 1;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  // configuration registers
  logic [madap_pkg::CMD_W-1:0] cmd_base_q;
  logic [madap_pkg::LAG_W-1:0] lag_q;

  // frame state
  logic [CH_W-1:0]    ch_q, ch_d;
  logic [RD_W-1:0]    rd_q, rd_d;
  logic [SLOT_CW-1:0] slot_q, slot_d;
  logic               bank_q, bank_d;
  logic               dac_ch_q, dac_ch_d;

  // sample line, newest at tap 0
  logic [SW-1:0] line_q [TOTAL];
  logic [SW-1:0] line_d [TOTAL];

  // result register
  logic                 out_valid_q;
  madap_pkg::result_t   res_q, res_d;

  logic                 accept;
  logic                 store_en;
  logic [SW-1:0]        new_sample;
  logic [LAGSUM_W-1:0]  lag_sum;
  logic [SUM_W-1:0]     avg_sum;
  logic [PROD_W-1:0]    avg_prod;
  logic [TAP_W:0]       dac_dist;
  logic [SW-1:0]        dac_sample;

  // Take a frame when the result register is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign store_en   = accept && rx_valid_i;
  assign new_sample = rx_sample_i ^ madap_pkg::SAMPLE_FLIP;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_base_q <= madap_pkg::CMD_BASE_RST;
      lag_q      <= madap_pkg::LAG_RST;
    end else if (cfg_we_i) begin
      unique case (madap_pkg::cfg_reg_e'(cfg_addr_i))
        madap_pkg::CFG_COMMAND_BASE: cmd_base_q <= cfg_data_i;
        madap_pkg::CFG_CHANNEL_LAG:  lag_q      <= cfg_data_i[madap_pkg::LAG_W-1:0];
      endcase
    end
  end

  // Lagged channel, reduced modulo the channel count by repeated subtraction
  always_comb begin
    lag_sum = LAGSUM_W'(ch_q) + LAGSUM_W'(lag_q);
    for (int i = 0; i < LAG_STEPS; i++) begin
      if (lag_sum >= LAGSUM_W'(NUM_CHANNELS)) begin
        lag_sum = lag_sum - LAGSUM_W'(NUM_CHANNELS);
      end
    end
  end

  // Sum the new sample with the same channel's earlier rounds on the line
  always_comb begin
    avg_sum = SUM_W'(new_sample);
    for (int k = 1; k < AVG_DEPTH; k++) begin
      avg_sum = avg_sum + SUM_W'(line_q[k * NUM_CHANNELS - 1]);
    end
    avg_prod = PROD_W'(avg_sum) * PROD_W'(RECIP);
  end

  // Shift the new sample into the line
  always_comb begin
    line_d = line_q;
    if (store_en) begin
      line_d[0] = new_sample;
      for (int i = 1; i < TOTAL; i++) begin
        line_d[i] = line_q[i - 1];
      end
    end
  end

  // Advance channel, round, slot and bank
  always_comb begin
    ch_d   = ch_q;
    rd_d   = rd_q;
    slot_d = slot_q;
    bank_d = bank_q;
    if (store_en) begin
      if (rd_q[0]) begin
        if (slot_q == SLOT_CW'(PACKET_WORDS - 1)) begin
          slot_d = '0;
          bank_d = !bank_q;
        end else begin
          slot_d = slot_q + SLOT_CW'(1);
        end
      end
      if (ch_q == CH_W'(NUM_CHANNELS - 1)) begin
        ch_d = '0;
        rd_d = (rd_q == RD_W'(AVG_DEPTH - 1)) ? '0 : rd_q + RD_W'(1);
      end else begin
        ch_d = ch_q + CH_W'(1);
      end
    end
  end

  // Locate the DAC channel's sample of the current round on the updated line
  always_comb begin
    dac_dist = (TAP_W + 1)'(ch_d) + (TAP_W + 1)'(TOTAL - 1) - (TAP_W + 1)'(dac_ch_q);
    if (dac_dist >= (TAP_W + 1)'(TOTAL)) begin
      dac_dist = dac_dist - (TAP_W + 1)'(TOTAL);
    end
    dac_sample = line_d[dac_dist[TAP_W-1:0]];
  end

  // Alternate the DAC channel on every accepted frame whose DAC has room
  assign dac_ch_d = (accept && dac_room_i) ? !dac_ch_q : dac_ch_q;

  // Assemble the result
  always_comb begin
    res_d = '0;
    res_d.adc_command = cmd_base_q
                      + (madap_pkg::CMD_W'(lag_sum) << madap_pkg::CMD_SHIFT);
    if (rx_valid_i && rd_q[0]) begin
      res_d.avg_valid   = 1'b1;
      res_d.avg_value   = avg_prod[DIV_SH +: SW];
      res_d.avg_channel = madap_pkg::AVG_CH_W'(ch_q);
      res_d.packet_slot = madap_pkg::SLOT_W'(slot_q);
      res_d.packet_bank = bank_q;
      res_d.packet_done = (slot_q == SLOT_CW'(PACKET_WORDS - 1));
    end
    if (dac_room_i) begin
      res_d.dac_valid = 1'b1;
      res_d.dac_word  = madap_pkg::DAC_FIXED
                      | (madap_pkg::DAC_W'(dac_ch_q) << madap_pkg::DAC_CH_BIT)
                      | madap_pkg::DAC_W'(dac_sample);
    end
  end

  // Hold frame state and the sample line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q     <= '0;
      rd_q     <= '0;
      slot_q   <= '0;
      bank_q   <= 1'b0;
      dac_ch_q <= 1'b0;
      for (int i = 0; i < TOTAL; i++) begin
        line_q[i] <= '0;
      end
    end else begin
      ch_q     <= ch_d;
      rd_q     <= rd_d;
      slot_q   <= slot_d;
      bank_q   <= bank_d;
      dac_ch_q <= dac_ch_d;
      line_q   <= line_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept;
    end
  end

  // Result payload, held while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign adc_command_o = res_q.adc_command;
  assign avg_valid_o   = res_q.avg_valid;
  assign avg_value_o   = res_q.avg_value;
  assign avg_channel_o = res_q.avg_channel;
  assign packet_slot_o = res_q.packet_slot;
  assign packet_bank_o = res_q.packet_bank;
  assign packet_done_o = res_q.packet_done;
  assign dac_valid_o   = res_q.dac_valid;
  assign dac_word_o    = res_q.dac_word;

endmodule

// File: sim/madap_frame_checker.sv
// Result checker for the ADC averager and packetiser: predicts each frame and compares results.
`timescale 1ns / 1ps

module madap_frame_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [madap_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [madap_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // frame requests
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic                             rx_valid_i,
  input  logic [madap_pkg::SAMPLE_W-1:0]   rx_sample_i,
  input  logic                             dac_room_i,
  // result requests
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [madap_pkg::CMD_W-1:0]      adc_command_i,
  input  logic                             avg_valid_i,
  input  logic [madap_pkg::SAMPLE_W-1:0]   avg_value_i,
  input  logic [madap_pkg::AVG_CH_W-1:0]   avg_channel_i,
  input  logic [madap_pkg::SLOT_W-1:0]     packet_slot_i,
  input  logic                             packet_bank_i,
  input  logic                             packet_done_i,
  input  logic                             dac_valid_i,
  input  logic [madap_pkg::DAC_W-1:0]      dac_word_i,
  // status towards the testbench top
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam int unsigned CHANNELS     = 8;
  localparam int unsigned ROUNDS       = 4;
  localparam int unsigned PACKET_SLOTS = 16;

  // Shadow copy of the registers and the averaging state
  logic [madap_pkg::CMD_W-1:0]    cmd_base;
  logic [madap_pkg::LAG_W-1:0]    lag;
  logic [madap_pkg::SAMPLE_W-1:0] sample_mem [ROUNDS][CHANNELS];
  logic [2:0]                     chan;
  logic [1:0]                     round;
  logic [madap_pkg::SLOT_W-1:0]   slot;
  logic                           bank;
  logic                           dac_chan;

  madap_pkg::result_t awaited_results [$];
  int                 error_count = 0;

  assign fail_count_o = error_count;

  // Count a wrong field, report only the first few
  task automatic check_field(input string name, input logic [madap_pkg::DAC_W-1:0] want,
                             input logic [madap_pkg::DAC_W-1:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Work out the result of one frame and advance the shadow state
  task automatic compute_frame_result(input logic rx_v,
                                      input logic [madap_pkg::SAMPLE_W-1:0] raw,
                                      input logic room, output madap_pkg::result_t r);
    logic [17:0] sum;
    logic [2:0]  lagged;
    r      = '0;
    lagged = chan + lag;
    r.adc_command = cmd_base + (madap_pkg::CMD_W'(lagged) << madap_pkg::CMD_SHIFT);
    if (rx_v) begin
      sample_mem[round][chan] = raw ^ madap_pkg::SAMPLE_FLIP;
      // Odd rounds close a boxcar window for this channel
      if (round[0]) begin
        sum = '0;
        for (int k = 0; k < ROUNDS; k++) sum += 18'(sample_mem[k][chan]);
        r.avg_valid   = 1'b1;
        r.avg_value   = sum[17:2];
        r.avg_channel = chan;
        r.packet_slot = slot;
        r.packet_bank = bank;
        if (slot == madap_pkg::SLOT_W'(PACKET_SLOTS - 1)) begin
          r.packet_done = 1'b1;
          bank          = ~bank;
        end
        slot = slot + 4'd1;
      end
      if (chan == 3'(CHANNELS - 1)) round = round + 2'd1;
      chan = chan + 3'd1;
    end
    // DAC reads the store after this frame's sample is in place
    if (room) begin
      r.dac_valid = 1'b1;
      r.dac_word  = madap_pkg::DAC_FIXED
                  | (madap_pkg::DAC_W'(dac_chan) << madap_pkg::DAC_CH_BIT)
                  | madap_pkg::DAC_W'(sample_mem[round][dac_chan]);
      dac_chan    = ~dac_chan;
    end
  endtask

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    madap_pkg::result_t want;
    madap_pkg::result_t got;
    madap_pkg::result_t predicted;
    if (!rst_ni) begin
      cmd_base = madap_pkg::CMD_BASE_RST;
      lag      = madap_pkg::LAG_RST;
      for (int r = 0; r < ROUNDS; r++)
        for (int c = 0; c < CHANNELS; c++) sample_mem[r][c] = '0;
      chan     = '0;
      round    = '0;
      slot     = '0;
      bank     = 1'b0;
      dac_chan = 1'b0;
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      // Compare a delivered result with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got = {adc_command_i, avg_valid_i, avg_value_i, avg_channel_i, packet_slot_i,
               packet_bank_i, packet_done_i, dac_valid_i, dac_word_i};
        if (awaited_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: result with no frame outstanding: %h", $time, got);
        end else begin
          want = awaited_results.pop_front();
          check_field("adc_command", want.adc_command, got.adc_command);
          check_field("avg_valid",   want.avg_valid,   got.avg_valid);
          check_field("avg_value",   want.avg_value,   got.avg_value);
          check_field("avg_channel", want.avg_channel, got.avg_channel);
          check_field("packet_slot", want.packet_slot, got.packet_slot);
          check_field("packet_bank", want.packet_bank, got.packet_bank);
          check_field("packet_done", want.packet_done, got.packet_done);
          check_field("dac_valid",   want.dac_valid,   got.dac_valid);
          check_field("dac_word",    want.dac_word,    got.dac_word);
        end
      end
      // Predict each accepted frame request
      if (in_valid_i && in_ready_i) begin
        compute_frame_result(rx_valid_i, rx_sample_i, dac_room_i, predicted);
        awaited_results.push_back(predicted);
      end
      // Track register writes
      if (cfg_we_i) begin
        case (madap_pkg::cfg_reg_e'(cfg_addr_i))
          madap_pkg::CFG_COMMAND_BASE: cmd_base = cfg_data_i;
          madap_pkg::CFG_CHANNEL_LAG:  lag      = cfg_data_i[madap_pkg::LAG_W-1:0];
          default: ;
        endcase
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

// File: sim/tb_multichannel_adc_average_packetizer_unit.sv
// Testbench top for the ADC averager and packetiser: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_multichannel_adc_average_packetizer_unit;

  localparam int HOLD_CYCLES  = 40;
  localparam int PHASE_FRAMES = 255;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             cfg_we     = 1'b0;
  logic [madap_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [madap_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
  logic                             in_valid   = 1'b0;
  logic                             rx_valid   = 1'b0;
  logic [madap_pkg::SAMPLE_W-1:0]   rx_sample  = '0;
  logic                             dac_room   = 1'b0;
  logic                             out_ready  = 1'b0;

  logic                             in_ready;
  logic                             out_valid;
  logic [madap_pkg::CMD_W-1:0]      adc_command;
  logic                             avg_valid;
  logic [madap_pkg::SAMPLE_W-1:0]   avg_value;
  logic [madap_pkg::AVG_CH_W-1:0]   avg_channel;
  logic [madap_pkg::SLOT_W-1:0]     packet_slot;
  logic                             packet_bank;
  logic                             packet_done;
  logic                             dac_valid;
  logic [madap_pkg::DAC_W-1:0]      dac_word;

  int fail_count;
  int pending;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_requests      = 0;
  int holds_served       = 0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multichannel_adc_average_packetizer_unit uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .rx_valid_i   (rx_valid),
    .rx_sample_i  (rx_sample),
    .dac_room_i   (dac_room),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .adc_command_o(adc_command),
    .avg_valid_o  (avg_valid),
    .avg_value_o  (avg_value),
    .avg_channel_o(avg_channel),
    .packet_slot_o(packet_slot),
    .packet_bank_o(packet_bank),
    .packet_done_o(packet_done),
    .dac_valid_o  (dac_valid),
    .dac_word_o   (dac_word)
  );

  madap_frame_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .rx_valid_i   (rx_valid),
    .rx_sample_i  (rx_sample),
    .dac_room_i   (dac_room),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .adc_command_i(adc_command),
    .avg_valid_i  (avg_valid),
    .avg_value_i  (avg_value),
    .avg_channel_i(avg_channel),
    .packet_slot_i(packet_slot),
    .packet_bank_i(packet_bank),
    .packet_done_i(packet_done),
    .dac_valid_i  (dac_valid),
    .dac_word_i   (dac_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offer one frame request after a random idle gap, hold it until taken
  task automatic send_frame(input logic rx_v, input logic [madap_pkg::SAMPLE_W-1:0] sample,
                            input logic room);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_valid  <= rx_v;
    rx_sample <= sample;
    dac_room  <= room;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has been delivered
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register; the block must be idle
  task automatic write_register(input madap_pkg::cfg_reg_e index,
                                input logic [madap_pkg::CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_addr <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Favour full-scale samples now and then so that sums reach their extremes
  function automatic logic [madap_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return madap_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no sample with a DAC read of the cleared store, then full-scale, 0 and FFFF
    send_frame(1'b0, 16'h7FFF, 1'b1);
    send_frame(1'b1, 16'h8000, 1'b1);
    send_frame(1'b1, 16'h7FFF, 1'b0);
    send_frame(1'b1, 16'h0000, 1'b1);
    send_frame(1'b1, 16'hFFFF, 1'b1);
    // Finish round zero and run through the first averaging round
    for (int k = 4; k < 16; k++)
      send_frame(1'b1, k[0] ? 16'h7FFF : 16'h8000, k[1]);
    // Even round: a frame with no sample, then one with a sample, both without DAC room
    send_frame(1'b0, 16'h1234, 1'b0);
    send_frame(1'b1, 16'h0001, 1'b0);
    drain_results();

    // Extremes of both registers: command word wraps, no lag
    write_register(madap_pkg::CFG_CHANNEL_LAG, 16'd0);
    write_register(madap_pkg::CFG_COMMAND_BASE, 16'hFFFF);
    send_frame(1'b1, 16'hFFFE, 1'b1);
    send_frame(1'b0, 16'h0000, 1'b1);
    send_frame(1'b1, 16'h5555, 1'b1);
    drain_results();

    // Random phases, each with its own settings and flow-control mix
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_register(madap_pkg::CFG_COMMAND_BASE, 16'h0000);
          write_register(madap_pkg::CFG_CHANNEL_LAG, 16'd7);
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          write_register(madap_pkg::CFG_COMMAND_BASE,
                         madap_pkg::CFG_DATA_W'($urandom_range(65535)));
          write_register(madap_pkg::CFG_CHANNEL_LAG,
                         madap_pkg::CFG_DATA_W'($urandom_range(7)));
          sender_idle_pct    = 72;
          receiver_stall_pct = 0;
        end
        2: begin
          write_register(madap_pkg::CFG_COMMAND_BASE, 16'h5A5A);
          write_register(madap_pkg::CFG_CHANNEL_LAG, 16'd4);
          sender_idle_pct    = 0;
          receiver_stall_pct = 72;
        end
        default: begin
          write_register(madap_pkg::CFG_COMMAND_BASE, madap_pkg::CMD_BASE_RST);
          write_register(madap_pkg::CFG_CHANNEL_LAG,
                         madap_pkg::CFG_DATA_W'(madap_pkg::LAG_RST));
          sender_idle_pct    = 22;
          receiver_stall_pct = 22;
        end
      endcase
      for (int i = 0; i < PHASE_FRAMES; i++) begin
        // Long receiver hold-off while frames keep coming
        if (phase == 0 && i == 50) hold_requests++;
        // Pause the sender until all results are home
        if (i == 120) drain_results();
        send_frame($urandom_range(99) < 88, pick_sample(), 1'($urandom_range(1)));
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
